FILE: rtl/core/stq_pkg.sv
// Shared constants, opcodes and a time helper for the sorted timer queue.
package stq_pkg;

    localparam int SEC_W  = 32;
    localparam int USEC_W = 20;
    localparam int ID_W   = 4;
    localparam int OP_W   = 2;

    localparam int DEF_MAX_TASKS          = 16;
    localparam int DEF_MAX_FIRES_PER_TICK = 16;
    localparam int RESULT_CAP             = 16;

    localparam logic [USEC_W:0] USEC_PER_SEC = 21'd1000000;

    localparam logic [OP_W-1:0] OP_SCHED  = 2'd0;
    localparam logic [OP_W-1:0] OP_CANCEL = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

    // a strictly later than b
    function automatic logic t_after(input logic [SEC_W-1:0] as, input logic [USEC_W-1:0] au,
                                     input logic [SEC_W-1:0] bs, input logic [USEC_W-1:0] bu);
        t_after = (as > bs) || ((as == bs) && (au > bu));
    endfunction

endpackage

FILE: rtl/core/sorted_timer_queue_core.sv
// Sorted timer queue: linked-list scheduler over task slots with periodic reload.
//
// The block keeps up to MAX_TASKS timer tasks in a deadline-ordered linked list held in
// small memories (deadline, period, successor) with one registered read per cycle. A
// small sequencer walks the list using a time compare and a seconds/microseconds adder:
// one entry per cycle while unlinking; while searching for the insert point each entry
// is read and then compared. A cancel of a slot that is not queued skips the unlink
// walk; a schedule unlinks a queued slot and then walks the list for the insert point.
// A tick unlinks the head for each firing and reinserts it when periodic, then works
// out the wait time. The input is stalled from acceptance until the last result
// word has been taken; results of one input then come out one per cycle when not
// stalled.
module sorted_timer_queue_core #(
    parameter int MAX_TASKS          = stq_pkg::DEF_MAX_TASKS,
    parameter int MAX_FIRES_PER_TICK = stq_pkg::DEF_MAX_FIRES_PER_TICK
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [stq_pkg::OP_W-1:0]    i_op,
    input  logic [stq_pkg::ID_W-1:0]    i_task_id,
    input  logic [stq_pkg::SEC_W-1:0]   i_now_sec,
    input  logic [stq_pkg::USEC_W-1:0]  i_now_usec,
    input  logic [stq_pkg::SEC_W-1:0]   i_delay_sec,
    input  logic [stq_pkg::USEC_W-1:0]  i_delay_usec,
    input  logic [stq_pkg::SEC_W-1:0]   i_period_sec,
    input  logic [stq_pkg::USEC_W-1:0]  i_period_usec,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic                        o_fired,
    output logic [stq_pkg::ID_W-1:0]    o_fired_task,
    output logic                        o_last,
    output logic                        o_queue_empty,
    output logic [stq_pkg::SEC_W-1:0]   o_wait_sec,
    output logic [stq_pkg::USEC_W-1:0]  o_wait_usec
);
    import stq_pkg::*;

    localparam int SW  = $clog2(MAX_TASKS);
    localparam int LW  = $clog2(MAX_TASKS + 1);
    localparam int CAP = (MAX_FIRES_PER_TICK < RESULT_CAP) ? MAX_FIRES_PER_TICK : RESULT_CAP;
    localparam int FW  = $clog2(CAP + 1);
    localparam int IW  = (CAP > 1) ? $clog2(CAP) : 1;
    localparam int TW  = SEC_W + USEC_W;

    typedef enum logic [4:0] {
        S_IDLE, S_PREP, S_UNL, S_UNL_HEAD, S_UNL_WALK, S_UNL_CMP, S_UNL_FIX, S_UNL_END,
        S_SCHED, S_ADD, S_NORM, S_INS_CHK, S_INS_CMP, S_INS_LINK, S_INS_HEAD,
        S_TICK_CHK, S_TICK_EVAL, S_TICK_RELOAD, S_WAIT_RD, S_WAIT_CALC, S_EMIT
    } t_state;

    // list storage
    logic [TW-1:0] mem_dl [MAX_TASKS];
    logic [TW-1:0] mem_pd [MAX_TASKS];
    logic [SW-1:0] mem_nx [MAX_TASKS];
    logic [TW-1:0] r_rd_dl, r_rd_pd;
    logic [SW-1:0] r_rd_nx;

    logic [MAX_TASKS-1:0] r_queued, n_queued;
    logic [SW-1:0] r_head, n_head;
    logic [LW-1:0] r_len, n_len;

    t_state r_state, n_state, r_after, n_after, r_ins_ret, n_ins_ret;

    logic [OP_W-1:0]   r_op, n_op;
    logic [ID_W-1:0]   r_id, n_id;
    logic              r_id_ok, n_id_ok;
    logic [SEC_W-1:0]  r_ns, n_ns, r_as, n_as, r_ps, n_ps, r_ts, n_ts, r_ws, n_ws;
    logic [USEC_W-1:0] r_nu, n_nu, r_au, n_au, r_pu, n_pu, r_wu, n_wu;
    logic [USEC_W:0]   r_tu, n_tu;
    logic [SW-1:0]     r_t, n_t, r_p, n_p, r_cur, n_cur, r_prev, n_prev;
    logic              r_hp, n_hp;
    logic [LW-1:0]     r_k, n_k;
    logic [FW-1:0]     r_fires, n_fires, r_e, n_e;
    logic [SW-1:0]     r_fbuf [CAP];

    // memory controls
    logic [SW-1:0] rd_addr, nx_wa, nx_wd;
    logic          dl_we, pd_we, nx_we, fb_we;

    logic [SEC_W-1:0]  rd_s;
    logic [USEC_W-1:0] rd_u;
    logic              rd_asap;
    logic [USEC_W:0]   borrow_u;

    assign rd_s     = r_rd_dl[TW-1:USEC_W];
    assign rd_u     = r_rd_dl[USEC_W-1:0];
    assign rd_asap  = (rd_s == '0) && (rd_u == '0);
    assign borrow_u = {1'b0, rd_u} + USEC_PER_SEC - {1'b0, r_nu};

    always_ff @(posedge i_clk) begin
        if (dl_we) mem_dl[r_t] <= {r_ts, r_tu[USEC_W-1:0]};
        if (pd_we) mem_pd[r_t] <= {r_ps, r_pu};
        if (nx_we) mem_nx[nx_wa] <= nx_wd;
        if (fb_we) r_fbuf[r_fires[IW-1:0]] <= r_head;
        r_rd_dl <= mem_dl[rd_addr];
        r_rd_pd <= mem_pd[rd_addr];
        r_rd_nx <= mem_nx[rd_addr];
    end

    always_comb begin
        n_state = r_state;   n_after = r_after;   n_ins_ret = r_ins_ret;
        n_queued = r_queued; n_head = r_head;     n_len = r_len;
        n_op = r_op; n_id = r_id; n_id_ok = r_id_ok;
        n_ns = r_ns; n_nu = r_nu; n_as = r_as; n_au = r_au; n_ps = r_ps; n_pu = r_pu;
        n_ts = r_ts; n_tu = r_tu; n_ws = r_ws; n_wu = r_wu;
        n_t = r_t; n_p = r_p; n_cur = r_cur; n_prev = r_prev; n_hp = r_hp; n_k = r_k;
        n_fires = r_fires; n_e = r_e;
        rd_addr = r_t; nx_wa = r_t; nx_wd = r_t;
        dl_we = 1'b0; pd_we = 1'b0; nx_we = 1'b0; fb_we = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_op = i_op; n_id = i_task_id;
                    n_id_ok = 32'(i_task_id) < MAX_TASKS;
                    n_ns = i_now_sec; n_nu = i_now_usec;
                    n_as = i_delay_sec; n_au = i_delay_usec;
                    n_ps = i_period_sec; n_pu = i_period_usec;
                    n_fires = '0;
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                if ({1'b0, r_nu} >= USEC_PER_SEC) begin
                    n_nu = r_nu - USEC_PER_SEC[USEC_W-1:0];
                    n_ns = r_ns + 1'b1;
                end
                n_t = SW'(r_id);
                n_ins_ret = S_WAIT_RD;
                if (r_op == OP_SCHED && r_id_ok) begin
                    n_after = S_SCHED;
                    n_state = S_UNL;
                end else if (r_op == OP_CANCEL && r_id_ok) begin
                    n_after = S_WAIT_RD;
                    n_state = S_UNL;
                end else if (r_op == OP_TICK) begin
                    n_state = S_TICK_CHK;
                end else begin
                    n_state = S_WAIT_RD;
                end
            end
            S_UNL: begin
                if (!r_queued[r_t]) begin
                    n_state = r_after;
                end else if (r_head == r_t) begin
                    rd_addr = r_t;
                    n_state = S_UNL_HEAD;
                end else begin
                    n_p = r_head;
                    n_state = S_UNL_WALK;
                end
            end
            S_UNL_HEAD: begin
                n_head = r_rd_nx;
                n_state = S_UNL_END;
            end
            S_UNL_WALK: begin
                rd_addr = r_p;
                n_state = S_UNL_CMP;
            end
            S_UNL_CMP: begin
                if (r_rd_nx == r_t) begin
                    rd_addr = r_t;
                    n_state = S_UNL_FIX;
                end else begin
                    n_p = r_rd_nx;
                    rd_addr = r_rd_nx;
                end
            end
            S_UNL_FIX: begin
                nx_we = 1'b1; nx_wa = r_p; nx_wd = r_rd_nx;
                n_state = S_UNL_END;
            end
            S_UNL_END: begin
                n_queued[r_t] = 1'b0;
                n_len = r_len - 1'b1;
                n_state = r_after;
            end
            S_SCHED: begin
                pd_we = 1'b1;
                if (r_as == '0 && r_au == '0) begin
                    n_ts = '0; n_tu = '0;
                    n_state = S_NORM;
                end else begin
                    n_ts = r_ns; n_tu = {1'b0, r_nu};
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                n_ts = r_ts + r_as;
                n_tu = r_tu + {1'b0, r_au};
                n_state = S_NORM;
            end
            S_NORM: begin
                if (r_tu >= USEC_PER_SEC) begin
                    n_tu = r_tu - USEC_PER_SEC;
                    n_ts = r_ts + 1'b1;
                end else begin
                    dl_we = 1'b1;
                    n_k = '0; n_cur = r_head; n_hp = 1'b0;
                    n_state = S_INS_CHK;
                end
            end
            S_INS_CHK: begin
                rd_addr = r_cur;
                n_state = (r_k < r_len) ? S_INS_CMP : S_INS_LINK;
            end
            S_INS_CMP: begin
                if (t_after(rd_s, rd_u, r_ts, r_tu[USEC_W-1:0])) begin
                    n_state = S_INS_LINK;
                end else begin
                    n_prev = r_cur; n_hp = 1'b1;
                    n_k = r_k + 1'b1;
                    n_cur = r_rd_nx;
                    n_state = S_INS_CHK;
                end
            end
            S_INS_LINK: begin
                nx_we = 1'b1; nx_wa = r_t;
                nx_wd = (r_k < r_len) ? r_cur : '0;
                n_state = S_INS_HEAD;
            end
            S_INS_HEAD: begin
                if (r_hp) begin
                    nx_we = 1'b1; nx_wa = r_prev; nx_wd = r_t;
                end else begin
                    n_head = r_t;
                end
                n_queued[r_t] = 1'b1;
                n_len = r_len + 1'b1;
                n_state = r_ins_ret;
            end
            S_TICK_CHK: begin
                rd_addr = r_head;
                if (r_len != '0 && r_fires < FW'(CAP)) n_state = S_TICK_EVAL;
                else n_state = S_WAIT_RD;
            end
            S_TICK_EVAL: begin
                if (!rd_asap && t_after(rd_s, rd_u, r_ns, r_nu)) begin
                    n_state = S_WAIT_RD;
                end else begin
                    fb_we = 1'b1;
                    n_fires = r_fires + 1'b1;
                    n_t = r_head;
                    n_ts = rd_asap ? r_ns : rd_s;
                    n_tu = rd_asap ? {1'b0, r_nu} : {1'b0, rd_u};
                    n_as = r_rd_pd[TW-1:USEC_W];
                    n_au = r_rd_pd[USEC_W-1:0];
                    n_after = S_TICK_RELOAD;
                    n_ins_ret = S_TICK_CHK;
                    n_state = S_UNL;
                end
            end
            S_TICK_RELOAD: begin
                n_state = (r_as != '0 || r_au != '0) ? S_ADD : S_TICK_CHK;
            end
            S_WAIT_RD: begin
                rd_addr = r_head;
                n_ws = '0; n_wu = '0; n_e = '0;
                n_state = (r_len != '0) ? S_WAIT_CALC : S_EMIT;
            end
            S_WAIT_CALC: begin
                if (!rd_asap && t_after(rd_s, rd_u, r_ns, r_nu)) begin
                    if (rd_u >= r_nu) begin
                        n_wu = rd_u - r_nu;
                        n_ws = rd_s - r_ns;
                    end else begin
                        n_wu = borrow_u[USEC_W-1:0];
                        n_ws = rd_s - r_ns - 1'b1;
                    end
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!i_stall) begin
                    if (o_last) n_state = S_IDLE;
                    else n_e = r_e + 1'b1;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_queued <= '0;
            r_head   <= '0;
            r_len    <= '0;
            r_fires  <= '0;
            r_e      <= '0;
        end else begin
            r_state  <= n_state;
            r_queued <= n_queued;
            r_head   <= n_head;
            r_len    <= n_len;
            r_fires  <= n_fires;
            r_e      <= n_e;
        end
        r_after <= n_after; r_ins_ret <= n_ins_ret;
        r_op <= n_op; r_id <= n_id; r_id_ok <= n_id_ok;
        r_ns <= n_ns; r_nu <= n_nu; r_as <= n_as; r_au <= n_au; r_ps <= n_ps; r_pu <= n_pu;
        r_ts <= n_ts; r_tu <= n_tu; r_ws <= n_ws; r_wu <= n_wu;
        r_t <= n_t; r_p <= n_p; r_cur <= n_cur; r_prev <= n_prev; r_hp <= n_hp; r_k <= n_k;
    end

    // result word: held steady while stalled
    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = (r_state == S_EMIT);
    assign o_fired       = (r_fires != '0);
    assign o_fired_task  = o_fired ? ID_W'(r_fbuf[r_e[IW-1:0]]) : '0;
    assign o_last        = (r_fires == '0) || (r_e == r_fires - 1'b1);
    assign o_queue_empty = (r_len == '0);
    assign o_wait_sec    = o_last ? r_ws : '0;
    assign o_wait_usec   = o_last ? r_wu : '0;

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_len) <= MAX_TASKS) else $error("queue length overflow");
    a_len_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (32'(r_len) == $countones(r_queued)))
        else $error("queue length disagrees with queued slots");
    a_fire_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fires) <= CAP) else $error("fire count over cap");
    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall) else $error("input open while results pending");

endmodule

FILE: bench/tb.sv
// Self-checking testbench for the sorted timer queue core.
`timescale 1ns / 1ps

module tb;
    import stq_pkg::*;

    localparam int  NSLOTS    = DEF_MAX_TASKS;
    localparam int  FIRE_CAP  = (DEF_MAX_FIRES_PER_TICK < RESULT_CAP) ?
                                DEF_MAX_FIRES_PER_TICK : RESULT_CAP;
    localparam int  CYCLE_CAP = 3000000;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic              fired;
        logic [ID_W-1:0]   task_id;
        logic              last;
        logic              empty;
        logic [SEC_W-1:0]  wsec;
        logic [USEC_W-1:0] wusec;
    } timer_word_t;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [OP_W-1:0]   i_op;
    logic [ID_W-1:0]   i_task_id;
    logic [SEC_W-1:0]  i_now_sec;
    logic [USEC_W-1:0] i_now_usec;
    logic [SEC_W-1:0]  i_delay_sec;
    logic [USEC_W-1:0] i_delay_usec;
    logic [SEC_W-1:0]  i_period_sec;
    logic [USEC_W-1:0] i_period_usec;
    logic              o_valid;
    logic              i_stall;
    logic              o_fired;
    logic [ID_W-1:0]   o_fired_task;
    logic              o_last;
    logic              o_queue_empty;
    logic [SEC_W-1:0]  o_wait_sec;
    logic [USEC_W-1:0] o_wait_usec;

    sorted_timer_queue_core DUT (.*);

    // mirror of the block's timer state; the list is kept as an ordered queue of slots
    logic [SEC_W-1:0]  due_sec [NSLOTS];
    logic [USEC_W-1:0] due_usec[NSLOTS];
    logic [SEC_W-1:0]  per_sec [NSLOTS];
    logic [USEC_W-1:0] per_usec[NSLOTS];
    int                slot_order[$];

    timer_word_t pending_results[$];
    int          n_errors, n_words, n_results, n_fired, n_cycles;
    bit          rx_busy_off;     // stretch with no receiver stalls

    // shared stimulus clock for well-formed traffic
    logic [SEC_W-1:0]  cur_sec;
    logic [USEC_W-1:0] cur_usec;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // normalized time sum, seconds wrap at 2^32
    function automatic void time_sum(input logic [SEC_W-1:0] as, input logic [USEC_W-1:0] au,
                                     input logic [SEC_W-1:0] bs, input logic [USEC_W-1:0] bu,
                                     output logic [SEC_W-1:0] rs, output logic [USEC_W-1:0] ru);
        logic [SEC_W-1:0] s;
        int unsigned      u;
        s = as + bs;
        u = au + bu;
        while (u >= 1000000) begin
            u = u - 1000000;
            s = s + 1;
        end
        rs = s;
        ru = u[USEC_W-1:0];
    endfunction

    function automatic bit later_than(input logic [SEC_W-1:0] as, input logic [USEC_W-1:0] au,
                                      input logic [SEC_W-1:0] bs, input logic [USEC_W-1:0] bu);
        return (as > bs) || ((as == bs) && (au > bu));
    endfunction

    function automatic void unlink_task(input int id);
        foreach (slot_order[i])
            if (slot_order[i] == id) begin
                slot_order.delete(i);
                return;
            end
    endfunction

    // stable insert: goes after every entry with an equal or earlier deadline
    function automatic void link_task(input int id);
        int pos;
        pos = slot_order.size();
        foreach (slot_order[i])
            if (later_than(due_sec[slot_order[i]], due_usec[slot_order[i]],
                           due_sec[id], due_usec[id])) begin
                pos = i;
                break;
            end
        slot_order.insert(pos, id);
    endfunction

    // applies one accepted word to the mirror and queues the result words it causes
    function automatic void predict_timer_word(
            input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
            input logic [SEC_W-1:0] ns_in, input logic [USEC_W-1:0] nu_in,
            input logic [SEC_W-1:0] ds, input logic [USEC_W-1:0] du,
            input logic [SEC_W-1:0] ps, input logic [USEC_W-1:0] pu);
        logic [SEC_W-1:0]  ns, ws, hs;
        logic [USEC_W-1:0] nu, wu, hu;
        int                fired_ids[$];
        int                h, nres;
        bit                asap;
        timer_word_t       w;
        time_sum(ns_in, nu_in, '0, '0, ns, nu);
        ws = '0;
        wu = '0;
        case (op)
            OP_SCHED: begin
                unlink_task(id);
                due_sec[id]  = '0;
                due_usec[id] = '0;
                if (ds != 0 || du != 0)
                    time_sum(ns, nu, ds, du, due_sec[id], due_usec[id]);
                per_sec[id]  = ps;
                per_usec[id] = pu;
                link_task(id);
            end
            OP_CANCEL: unlink_task(id);
            OP_TICK: begin
                while (slot_order.size() > 0 && fired_ids.size() < FIRE_CAP) begin
                    h    = slot_order[0];
                    asap = (due_sec[h] == 0) && (due_usec[h] == 0);
                    if (!asap && later_than(due_sec[h], due_usec[h], ns, nu))
                        break;
                    void'(slot_order.pop_front());
                    fired_ids.push_back(h);
                    if (per_sec[h] != 0 || per_usec[h] != 0) begin
                        if (asap) begin
                            due_sec[h]  = ns;
                            due_usec[h] = nu;
                        end
                        time_sum(due_sec[h], due_usec[h], per_sec[h], per_usec[h],
                                 due_sec[h], due_usec[h]);
                        link_task(h);
                    end
                end
            end
            default: ;
        endcase
        if (slot_order.size() > 0) begin
            hs = due_sec[slot_order[0]];
            hu = due_usec[slot_order[0]];
            if (!(hs == 0 && hu == 0) && later_than(hs, hu, ns, nu)) begin
                if (hu >= nu) begin
                    wu = hu - nu;
                    ws = hs - ns;
                end else begin
                    wu = hu + 20'd1000000 - nu;
                    ws = hs - ns - 1;
                end
            end
        end
        nres = (fired_ids.size() == 0) ? 1 : fired_ids.size();
        for (int k = 0; k < nres; k++) begin
            w.fired   = fired_ids.size() > 0;
            w.task_id = (fired_ids.size() > 0) ? fired_ids[k][ID_W-1:0] : '0;
            w.last    = (k == nres - 1);
            w.empty   = slot_order.size() == 0;
            w.wsec    = w.last ? ws : '0;
            w.wusec   = w.last ? wu : '0;
            pending_results.push_back(w);
        end
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("ERROR t=%0t %s: got %0h expected %0h", $time, what, got, want);
        n_errors++;
    endtask

    // sends one word; valid stays high into the next word when no gap follows
    task automatic send_word(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                             input logic [SEC_W-1:0] ns, input logic [USEC_W-1:0] nu,
                             input logic [SEC_W-1:0] ds, input logic [USEC_W-1:0] du,
                             input logic [SEC_W-1:0] ps, input logic [USEC_W-1:0] pu,
                             input int gap);
        i_valid       <= 1'b1;
        i_op          <= op;
        i_task_id     <= id;
        i_now_sec     <= ns;
        i_now_usec    <= nu;
        i_delay_sec   <= ds;
        i_delay_usec  <= du;
        i_period_sec  <= ps;
        i_period_usec <= pu;
        do @(posedge i_clk); while (o_stall);
        predict_timer_word(op, id, ns, nu, ds, du, ps, pu);
        n_words++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // schedule/cancel/tick in the simple cases, including unqueued cancel and the unused op
    task automatic test_basic_ops();
        send_word(OP_TICK, 0, 32'd10, 0, 0, 0, 0, 0, 0);
        send_word(OP_SCHED, 3, 32'd10, 0, 32'd2, 20'd500000, 0, 0, 1);
        send_word(OP_SCHED, 5, 32'd10, 0, 0, 0, 32'd1, 0, 0);            // ASAP, periodic
        send_word(OP_SCHED, 7, 32'd10, 0, 32'd2, 20'd500000, 0, 0, 2);   // equal deadline
        send_word(OP_CANCEL, 9, 32'd10, 0, 0, 0, 0, 0, 0);               // not queued
        send_word(OP_TICK, 0, 32'd11, 20'd999999, 0, 0, 0, 0, 0);
        send_word(OP_TICK, 0, 32'd12, 20'd500000, 0, 0, 0, 0, 3);        // due exactly now
        send_word(OP_UNUSED, 2, 32'd13, 0, 0, 0, 0, 0, 0);
        send_word(OP_SCHED, 5, 32'd13, 0, 32'd1, 0, 0, 0, 0);            // reschedule queued
        send_word(OP_CANCEL, 5, 32'd13, 0, 0, 0, 0, 0, 0);
    endtask

    // field extremes: all-ones seconds, wrap, oversized microseconds carried into seconds
    task automatic test_time_extremes();
        send_word(OP_SCHED, 15, '1, 20'd999999, 0, 20'd1, '1, 20'd999999, 0);
        send_word(OP_SCHED, 0, '1, '1, '1, '1, 0, '1, 0);
        send_word(OP_SCHED, 1, 0, 0, '1, 20'd999999, 0, 0, 0);
        send_word(OP_TICK, 0, '1, '1, 0, 0, 0, 0, 0);
        send_word(OP_TICK, 0, 0, 20'd1, 0, 0, 0, 0, 0);
        for (int i = 0; i < NSLOTS; i++)
            send_word(OP_CANCEL, ID_W'(i), 0, 0, 0, 0, 0, 0, 0);
    endtask

    // sixteen due periodic tasks: the per-tick limit is hit and reinserted tasks stay due
    task automatic test_fire_limit();
        for (int i = 0; i < NSLOTS; i++)
            send_word(OP_SCHED, ID_W'(i), 32'd100, 0, 0, 20'd1, 0, 20'd1, 0);
        send_word(OP_TICK, 0, 32'd200, 0, 0, 0, 0, 0, 0);
        send_word(OP_TICK, 0, 32'd200, 0, 0, 0, 0, 0, 0);
        for (int i = 0; i < NSLOTS; i++)
            send_word(OP_SCHED, ID_W'(i), 32'd300, 0, 0, 0, 0, 20'd1, 0);   // all ASAP
        send_word(OP_TICK, 0, 32'd300, 0, 0, 0, 0, 0, 0);
        for (int i = 0; i < NSLOTS; i++)
            send_word(OP_CANCEL, ID_W'(i), 0, 0, 0, 0, 0, 0, 0);
    endtask

    // mostly coherent traffic on an advancing clock, plus full-range noise
    task automatic test_random_traffic(input int count);
        logic [OP_W-1:0]   op;
        logic [SEC_W-1:0]  ds, ps;
        logic [USEC_W-1:0] du, pu;
        int                gap;
        cur_sec  = 32'd1000;
        cur_usec = 0;
        for (int n = 0; n < count; n++) begin
            gap = rx_busy_off ? 0 : pick_gap();
            if (n == count / 2) begin
                i_valid <= 1'b0;
                wait_drained();          // sender holds off until everything is back
                repeat (20) @(posedge i_clk);
            end
            if (n % 60 == 30) rx_busy_off = ~rx_busy_off;
            if ($urandom_range(0, 99) < 75) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: op = OP_SCHED;
                    4: op = OP_CANCEL;
                    default: op = OP_TICK;
                endcase
                ds = $urandom_range(0, 2);
                du = ($urandom_range(0, 4) == 0) ? 20'd0 : USEC_W'($urandom_range(0, 999999));
                if ($urandom_range(0, 2) == 0) begin
                    ps = 0;
                    pu = 0;
                end else begin
                    ps = $urandom_range(0, 1);
                    pu = USEC_W'($urandom_range(1, 999999));
                end
                if (op == OP_TICK)
                    time_sum(cur_sec, cur_usec, SEC_W'($urandom_range(0, 1)),
                             USEC_W'($urandom_range(0, 999999)), cur_sec, cur_usec);
                send_word(op, ID_W'($urandom_range(0, NSLOTS - 1)), cur_sec, cur_usec,
                          ds, du, ps, pu, gap);
            end else begin
                send_word(OP_W'($urandom_range(0, 3)), ID_W'($urandom), $urandom,
                          USEC_W'($urandom), $urandom, USEC_W'($urandom), $urandom,
                          USEC_W'($urandom), gap);
            end
        end
        i_valid <= 1'b0;
    endtask

    // receiver stalls
    int rx_hold;
    always @(posedge i_clk) begin
        if (rx_busy_off) begin
            i_stall <= 1'b0;
        end else if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            i_stall <= 1'b1;
        end else begin
            rx_hold <= pick_gap();
            i_stall <= 1'b0;
        end
    end

    // result checker
    always @(posedge i_clk) begin
        timer_word_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            n_results++;
            if (pending_results.size() == 0) begin
                $display("ERROR t=%0t result word with nothing expected", $time);
                n_errors++;
            end else begin
                want = pending_results.pop_front();
                if (o_fired) n_fired++;
                if (o_fired !== want.fired) report_mismatch("fired", o_fired, want.fired);
                if (o_fired_task !== want.task_id)
                    report_mismatch("fired_task", o_fired_task, want.task_id);
                if (o_last !== want.last) report_mismatch("last", o_last, want.last);
                if (o_queue_empty !== want.empty)
                    report_mismatch("queue_empty", o_queue_empty, want.empty);
                if (o_wait_sec !== want.wsec) report_mismatch("wait_sec", o_wait_sec, want.wsec);
                if (o_wait_usec !== want.wusec)
                    report_mismatch("wait_usec", o_wait_usec, want.wusec);
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles >= CYCLE_CAP) begin
            $display("ERROR: timeout with %0d results outstanding", pending_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_stall = 1'b0;
        i_op = OP_SCHED;
        i_task_id = '0;
        i_now_sec = '0;
        i_now_usec = '0;
        i_delay_sec = '0;
        i_delay_usec = '0;
        i_period_sec = '0;
        i_period_usec = '0;
        rx_hold = 0;
        rx_busy_off = 1'b0;
        n_errors = 0;
        n_words = 0;
        n_results = 0;
        n_fired = 0;
        n_cycles = 0;
        for (int i = 0; i < NSLOTS; i++) begin
            due_sec[i] = '0;
            due_usec[i] = '0;
            per_sec[i] = '0;
            per_usec[i] = '0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_basic_ops();
        test_time_extremes();
        test_fire_limit();
        test_random_traffic(250);

        wait_drained();
        repeat (200) @(posedge i_clk);
        $display("Covered %0d input words: schedule, cancel, tick, unused op, fire limit,",
                 n_words);
        $display("time wrap and carry; %0d result words checked, %0d firings.",
                 n_results, n_fired);
        if (n_errors == 0 && pending_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
